// File: sv/i2c_master_bit_sequencer_assert.svh
// Assertion macros for the I2C bit sequencer.
// IMP checks a same-cycle implication, NEXT checks the cycle after.
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CBS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define I2CBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define I2CBS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define I2CBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: sv/i2cbs_pkg.sv
package i2cbs_pkg;

  localparam int unsigned TICK_W = 10;
  localparam int unsigned STEP_W = 5;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 10'd10;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] byte_data;
    logic       last_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_byte;
    logic       command_ignored;
  } result_t;

endpackage

// File: sv/i2cbs_core.sv
module i2cbs_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [i2cbs_pkg::TICK_W-1:0] cfg_data,
  input  logic                        fire,
  input  i2cbs_pkg::item_t            item,
  output i2cbs_pkg::result_t          res
);
  import i2cbs_pkg::*;

  `include "i2c_master_bit_sequencer_assert.svh"

  localparam logic [STEP_W-1:0] WR_ACK_STEP  = 5'd24;
  localparam logic [STEP_W-1:0] WR_SMP_STEP  = 5'd25;
  localparam logic [STEP_W-1:0] WR_END_STEP  = 5'd26;
  localparam logic [STEP_W-1:0] WR_STOP_STEP = 5'd27;
  localparam logic [STEP_W-1:0] WR_LAST_STEP = 5'd30;
  localparam logic [STEP_W-1:0] RD_LAST_STEP = 5'd15;
  localparam logic [STEP_W-1:0] SS_LAST_STEP = 5'd3;

  typedef enum logic [4:0] {
    OP_IDLE  = 5'b00001,
    OP_START = 5'b00010,
    OP_STOP  = 5'b00100,
    OP_WRITE = 5'b01000,
    OP_READ  = 5'b10000
  } op_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } line_t;

  typedef struct packed {
    line_t      lines;
    logic [7:0] shift;
  } phase_t;

  function automatic line_t stop_lines(logic [1:0] k, line_t ln);
    line_t r;
    r = ln;
    r.drv = 1'b1;
    unique case (k)
      2'd0: r.sda = 1'b0;
      2'd1: r.scl = 1'b1;
      2'd2: r.sda = 1'b1;
      default: r.scl = 1'b0;
    endcase
    return r;
  endfunction

  // Line update at the start of a phase.
  function automatic phase_t enter_phase(op_t op, logic [STEP_W-1:0] s, logic [1:0] k3,
                                         logic [7:0] shift, line_t ln);
    phase_t            r;
    logic [STEP_W-1:0] sk;
    r.lines = ln;
    r.shift = shift;
    sk = s - WR_STOP_STEP;
    unique case (op)
      OP_START: begin
        r.lines.drv = 1'b1;
        unique case (s[1:0])
          2'd0: r.lines.sda = 1'b1;
          2'd1: r.lines.scl = 1'b1;
          2'd2: r.lines.sda = 1'b0;
          default: r.lines.scl = 1'b0;
        endcase
      end
      OP_STOP: r.lines = stop_lines(s[1:0], ln);
      OP_WRITE: begin
        if (s < WR_ACK_STEP) begin
          r.lines.drv = 1'b1;
          if (k3 == 2'd0) begin
            r.lines.sda = shift[7];
            r.shift = {shift[6:0], 1'b0};
          end else if (k3 == 2'd1) begin
            r.lines.scl = 1'b1;
          end else begin
            r.lines.scl = 1'b0;
          end
        end else if (s == WR_ACK_STEP) begin
          r.lines.sda = 1'b1;
          r.lines.drv = 1'b1;
        end else if (s == WR_SMP_STEP) begin
          r.lines.scl = 1'b1;
          r.lines.drv = 1'b0;
        end else if (s == WR_END_STEP) begin
          r.lines.scl = 1'b0;
          r.lines.drv = 1'b1;
        end else begin
          r.lines = stop_lines(sk[1:0], ln);
        end
      end
      OP_READ: begin
        if (!s[0]) begin
          r.lines.scl = 1'b0;
          r.lines.sda = 1'b1;
          r.lines.drv = 1'b1;
        end else begin
          r.lines.scl = 1'b1;
          r.lines.drv = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic op_t cmd_to_op(logic [2:0] cmd);
    op_t r;
    unique case (cmd)
      CMD_START: r = OP_START;
      CMD_STOP:  r = OP_STOP;
      CMD_WRITE: r = OP_WRITE;
      CMD_READ:  r = OP_READ;
      default:   r = OP_IDLE;
    endcase
    return r;
  endfunction

  logic [TICK_W-1:0] phase_ticks;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  logic [STEP_W-1:0] step_index, step_index_next;
  logic [1:0]        bit_phase, bit_phase_next;
  op_t               op, op_next;
  logic [7:0]        shift_reg, shift_reg_next;
  logic              stop_pending, stop_pending_next;
  line_t             lines, lines_next;
  logic              ack_flag, ack_flag_next;
  logic [7:0]        read_reg, read_reg_next;

  logic              is_cmd;
  logic              finish;
  logic              done;
  logic              ignored;
  logic [TICK_W-1:0] len;
  logic [TICK_W-1:0] tick_inc;
  phase_t            ep;

  assign is_cmd   = (item.command >= CMD_START) && (item.command <= CMD_READ);
  assign len      = (phase_ticks == '0) ? TICK_W'(1) : phase_ticks;
  assign tick_inc = tick_count + TICK_W'(1);

  always_comb begin
    tick_count_next   = tick_count;
    step_index_next   = step_index;
    bit_phase_next    = bit_phase;
    op_next           = op;
    shift_reg_next    = shift_reg;
    stop_pending_next = stop_pending;
    lines_next        = lines;
    ack_flag_next     = ack_flag;
    read_reg_next     = read_reg;
    finish            = 1'b0;
    done              = 1'b0;
    ignored           = 1'b0;
    ep                = '0;
    if (op == OP_IDLE) begin
      if (is_cmd) begin
        op_next         = cmd_to_op(item.command);
        step_index_next = '0;
        tick_count_next = '0;
        bit_phase_next  = 2'd0;
        if (item.command == CMD_WRITE) begin
          shift_reg_next    = item.byte_data;
          stop_pending_next = item.last_byte;
        end else begin
          shift_reg_next    = '0;
          stop_pending_next = 1'b0;
        end
        ep             = enter_phase(op_next, '0, 2'd0, shift_reg_next, lines);
        lines_next     = ep.lines;
        shift_reg_next = ep.shift;
      end
    end else if (is_cmd) begin
      ignored = 1'b1;
    end else if (tick_inc >= len) begin
      tick_count_next = '0;
      // close the current phase
      unique case (op)
        OP_START, OP_STOP: finish = (step_index >= SS_LAST_STEP);
        OP_WRITE: begin
          if (step_index == WR_SMP_STEP) ack_flag_next = ~item.sda_in;
          if ((step_index == WR_END_STEP) && !stop_pending && ack_flag) finish = 1'b1;
          if (step_index >= WR_LAST_STEP) finish = 1'b1;
        end
        OP_READ: begin
          if (step_index[0]) shift_reg_next = {shift_reg[6:0], item.sda_in};
          if (step_index >= RD_LAST_STEP) begin
            read_reg_next  = shift_reg_next;
            lines_next.scl = 1'b0;
            lines_next.drv = 1'b1;
            finish         = 1'b1;
          end
        end
        default: finish = 1'b1;
      endcase
      if (finish) begin
        op_next           = OP_IDLE;
        step_index_next   = '0;
        stop_pending_next = 1'b0;
        done              = 1'b1;
      end else begin
        step_index_next = step_index + STEP_W'(1);
        bit_phase_next  = (bit_phase == 2'd2) ? 2'd0 : bit_phase + 2'd1;
        ep              = enter_phase(op, step_index_next, bit_phase_next, shift_reg_next,
                                      lines_next);
        lines_next      = ep.lines;
        shift_reg_next  = ep.shift;
      end
    end else begin
      tick_count_next = tick_inc;
    end
  end

  always_comb begin
    res.scl             = lines_next.scl;
    res.sda_level       = lines_next.sda;
    res.sda_drive       = lines_next.drv;
    res.busy_res        = (op_next != OP_IDLE);
    res.done_res        = done;
    res.ack_ok          = ack_flag_next;
    res.read_byte       = read_reg_next;
    res.command_ignored = ignored;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      step_index   <= '0;
      bit_phase    <= 2'd0;
      op           <= OP_IDLE;
      shift_reg    <= '0;
      stop_pending <= 1'b0;
      lines        <= '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
      ack_flag     <= 1'b0;
      read_reg     <= '0;
    end else if (fire) begin
      tick_count   <= tick_count_next;
      step_index   <= step_index_next;
      bit_phase    <= bit_phase_next;
      op           <= op_next;
      shift_reg    <= shift_reg_next;
      stop_pending <= stop_pending_next;
      lines        <= lines_next;
      ack_flag     <= ack_flag_next;
      read_reg     <= read_reg_next;
    end
  end

  `I2CBS_ASSERT_NEXT(a_done_idle, clk, rst, fire && res.done_res, op == OP_IDLE, "done without return to idle")
  `I2CBS_ASSERT_NEXT(a_ignored_hold, clk, rst, fire && res.command_ignored, $stable(tick_count) && $stable(step_index), "dropped command moved the sequencer")
  `I2CBS_ASSERT_IMP(a_idle_step, clk, rst, op == OP_IDLE, step_index == '0 && !stop_pending, "idle with live step state")
  `I2CBS_ASSERT_IMP(a_read_range, clk, rst, op == OP_READ, step_index <= RD_LAST_STEP, "read step out of range")

endmodule

// File: sv/i2c_master_bit_sequencer.sv
// Channel   Direction  Payload
// s_axis    in         tuser: command[2:0]; tlast: last_byte; tdata: byte_data, sda_in
// m_axis    out        tdata: line levels, status, read_byte, command_ignored
// cfg       in         data: phase_ticks[9:0]
//
// One item per cycle while the output is not stalled: an input register feeds
// the sequencer logic, whose result lands in the output register on the same
// edge the state advances. Synchronous reset clears all control state;
// phase_ticks returns to 10. A stalled output holds the input register;
// the input side then takes one more item only if the input register is empty.
module i2c_master_bit_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // byte_data[7:0], sda_in[8], zero pad
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4], ack_ok[5],
  // read_byte[13:6], command_ignored[14], zero pad
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);
  import i2cbs_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    fire;
  result_t res;
  result_t out_res;

  assign fire          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.command   <= s_axis_tuser;
      in_item.byte_data <= s_axis_tdata[7:0];
      in_item.last_byte <= s_axis_tlast;
      in_item.sda_in    <= s_axis_tdata[8];
    end
  end

  i2cbs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .fire     (fire),
    .item     (in_item),
    .res      (res)
  );

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_res.command_ignored, out_res.read_byte, out_res.ack_ok,
                         out_res.done_res, out_res.busy_res, out_res.sda_drive,
                         out_res.sda_level, out_res.scl};

endmodule

// File: verif/i2c_master_bit_sequencer_tb.sv
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_tb;
  import i2cbs_pkg::*;

  localparam logic [2:0] OP_IDLE = CMD_TICK;
  localparam logic [5:0] WR_ACK_STEP = 6'd24;
  localparam logic [5:0] WR_STOP_STEP = 6'd27;
  localparam logic [5:0] WR_LAST_STEP = 6'd30;
  localparam logic [5:0] RD_LAST_STEP = 6'd15;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;

  // Tracks the line sequencer and holds the line states due on the output.
  class line_sequence_model;
    logic [9:0] phase_len;
    logic [9:0] tick_cnt;
    logic [5:0] step;
    logic [2:0] op;
    logic [7:0] shreg;
    logic       stop_pend;
    logic       scl;
    logic       sda;
    logic       drv;
    logic       ack;
    logic [7:0] rd_byte;
    result_t    line_states_due[$];
    int         errors;

    function new();
      phase_len = PHASE_TICKS_RESET;
      tick_cnt = '0;
      step = '0;
      op = OP_IDLE;
      shreg = '0;
      stop_pend = 1'b0;
      scl = 1'b0;
      sda = 1'b1;
      drv = 1'b1;
      ack = 1'b0;
      rd_byte = '0;
      errors = 0;
    endfunction

    function void set_phase_ticks(logic [9:0] v);
      phase_len = v;
    endfunction

    function bit busy();
      return op != OP_IDLE;
    endfunction

    function int outstanding();
      return line_states_due.size();
    endfunction

    function void stop_pattern(logic [1:0] k);
      drv = 1'b1;
      case (k)
        2'd0: sda = 1'b0;
        2'd1: scl = 1'b1;
        2'd2: sda = 1'b1;
        default: scl = 1'b0;
      endcase
    endfunction

    // Set the lines for the phase that step now points at.
    function void enter_line_phase();
      logic [5:0] k;
      case (op)
        CMD_START: begin
          drv = 1'b1;
          if (step == 6'd0) sda = 1'b1;
          else if (step == 6'd1) scl = 1'b1;
          else if (step == 6'd2) sda = 1'b0;
          else scl = 1'b0;
        end
        CMD_STOP: stop_pattern(step[1:0]);
        CMD_WRITE: begin
          if (step < WR_ACK_STEP) begin
            k = step % 6'd3;
            drv = 1'b1;
            if (k == 6'd0) begin
              sda = shreg[7];
              shreg = {shreg[6:0], 1'b0};
            end else if (k == 6'd1) begin
              scl = 1'b1;
            end else begin
              scl = 1'b0;
            end
          end else if (step == WR_ACK_STEP) begin
            sda = 1'b1;
            drv = 1'b1;
          end else if (step == WR_ACK_STEP + 6'd1) begin
            scl = 1'b1;
            drv = 1'b0;
          end else if (step == WR_ACK_STEP + 6'd2) begin
            scl = 1'b0;
            drv = 1'b1;
          end else begin
            k = step - WR_STOP_STEP;
            stop_pattern(k[1:0]);
          end
        end
        CMD_READ: begin
          if (!step[0]) begin
            scl = 1'b0;
            sda = 1'b1;
            drv = 1'b1;
          end else begin
            scl = 1'b1;
            drv = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    // Close the current phase; return 1 when the whole sequence is over.
    function bit close_line_phase(logic sda_in);
      case (op)
        CMD_START, CMD_STOP: begin
          if (step >= 6'd3) return 1'b1;
        end
        CMD_WRITE: begin
          if (step == WR_ACK_STEP + 6'd1) ack = !sda_in;
          // ACK without a pending stop ends the write right after the ack clock
          if (step == WR_ACK_STEP + 6'd2 && !stop_pend && ack) return 1'b1;
          if (step >= WR_LAST_STEP) return 1'b1;
        end
        CMD_READ: begin
          if (step[0]) shreg = {shreg[6:0], sda_in};
          if (step >= RD_LAST_STEP) begin
            rd_byte = shreg;
            scl = 1'b0;
            drv = 1'b1;
            return 1'b1;
          end
        end
        default: return 1'b1;
      endcase
      step = step + 6'd1;
      enter_line_phase();
      return 1'b0;
    endfunction

    function void note_item(item_t it);
      logic       done;
      logic       ignored;
      logic       is_cmd;
      logic [9:0] len;
      result_t    r;
      done = 1'b0;
      ignored = 1'b0;
      is_cmd = (it.command >= CMD_START) && (it.command <= CMD_READ);
      if (op == OP_IDLE) begin
        if (is_cmd) begin
          op = it.command;
          step = '0;
          tick_cnt = '0;
          if (it.command == CMD_WRITE) begin
            shreg = it.byte_data;
            stop_pend = it.last_byte;
          end else begin
            shreg = '0;
            stop_pend = 1'b0;
          end
          enter_line_phase();
        end
      end else if (is_cmd) begin
        ignored = 1'b1;
      end else begin
        len = (phase_len == '0) ? 10'd1 : phase_len;
        tick_cnt = tick_cnt + 10'd1;
        if (tick_cnt >= len) begin
          tick_cnt = '0;
          if (close_line_phase(it.sda_in)) begin
            op = OP_IDLE;
            step = '0;
            stop_pend = 1'b0;
            done = 1'b1;
          end
        end
      end
      r.scl = scl;
      r.sda_level = sda;
      r.sda_drive = drv;
      r.busy_res = (op != OP_IDLE);
      r.done_res = done;
      r.ack_ok = ack;
      r.read_byte = rd_byte;
      r.command_ignored = ignored;
      line_states_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [15:0] d);
      result_t want;
      if (line_states_due.size() == 0) begin
        $error("result %h arrived with nothing expected", d);
        errors++;
        return;
      end
      want = line_states_due.pop_front();
      compare_field("scl", want.scl, d[0]);
      compare_field("sda_level", want.sda_level, d[1]);
      compare_field("sda_drive", want.sda_drive, d[2]);
      compare_field("busy_res", want.busy_res, d[3]);
      compare_field("done_res", want.done_res, d[4]);
      compare_field("ack_ok", want.ack_ok, d[5]);
      compare_field("read_byte", want.read_byte, d[13:6]);
      compare_field("command_ignored", want.command_ignored, d[14]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = '0;

  line_sequence_model seq_model = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_off_request = 1'b0;
  int hold_off_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  i2c_master_bit_sequencer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receive side: check each transfer, then pick tready for the next edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) seq_model.check_result(m_axis_tdata);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("i2c_master_bit_sequencer_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(logic [2:0] cmd, logic [7:0] data, logic last, logic sda_in);
    item_t it;
    it.command = cmd;
    it.byte_data = data;
    it.last_byte = last;
    it.sda_in = sda_in;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tlast <= last;
    s_axis_tdata <= {7'b0, sda_in, data};
    do @(posedge clk); while (!s_axis_tready);
    seq_model.note_item(it);
    items_sent++;
  endtask

  // sda_sel: 0 or 1 holds SDA at that level, 2 randomizes it per tick.
  task automatic run_sequence(logic [2:0] cmd, logic [7:0] data, logic last, int sda_sel,
                              bit noisy);
    logic sda_in;
    send_item(cmd, data, last, (sda_sel == 2) ? 1'($urandom_range(1)) : 1'(sda_sel));
    while (seq_model.busy()) begin
      sda_in = (sda_sel == 2) ? 1'($urandom_range(1)) : 1'(sda_sel);
      if (noisy && $urandom_range(19) == 0) begin
        send_item(3'($urandom_range(CMD_START, CMD_READ)), 8'($urandom),
                  1'($urandom_range(1)), sda_in);
      end else if (noisy && $urandom_range(9) == 0) begin
        send_item(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom_range(1)), sda_in);
      end else begin
        send_item(CMD_TICK, 8'($urandom), 1'($urandom_range(1)), sda_in);
      end
    end
  endtask

  task automatic settle_and_configure(logic [9:0] ticks);
    while (seq_model.busy()) send_item(CMD_TICK, 8'($urandom), 1'($urandom_range(1)), 1'b1);
    s_axis_tvalid <= 1'b0;
    while (seq_model.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seq_model.set_phase_ticks(ticks);
  endtask

  task automatic run_random_phase(logic [9:0] ticks, int idle_pct, int stall_pct,
                                  int budget, bit hold_off);
    int first;
    settle_and_configure(ticks);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    if (hold_off) hold_off_request = 1'b1;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(9) == 0) begin
        // loose items, some of which start a sequence on their own
        repeat ($urandom_range(1, 4))
          send_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end else begin
        run_sequence(3'($urandom_range(CMD_START, CMD_READ)), 8'($urandom),
                     1'($urandom_range(1)), 2, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset phase length: idle items, then a start with a read that must be dropped
    send_item(CMD_TICK, 8'hFF, 1'b1, 1'b1);
    send_item(3'd7, 8'h00, 1'b0, 1'b0);
    send_item(CMD_START, 8'h00, 1'b0, 1'b1);
    send_item(CMD_READ, 8'hFF, 1'b1, 1'b0);
    send_item(3'd5, 8'h00, 1'b0, 1'b1);
    send_item(3'd6, 8'h00, 1'b0, 1'b0);
    while (seq_model.busy()) send_item(CMD_TICK, 8'h00, 1'b0, 1'b0);

    // Zero phase length behaves as one tick per phase
    settle_and_configure(10'd0);
    run_sequence(CMD_STOP, 8'h00, 1'b0, 0, 1'b0);
    run_sequence(CMD_WRITE, 8'hFF, 1'b1, 0, 1'b0);
    run_sequence(CMD_WRITE, 8'h00, 1'b0, 1, 1'b0);
    run_sequence(CMD_READ, 8'h00, 1'b0, 1, 1'b0);

    run_random_phase(10'd1, 0, 0, 250, 1'b0);
    run_random_phase(10'd2, 60, 0, 250, 1'b0);
    run_random_phase(10'd1, 0, 60, 250, 1'b1);
    run_random_phase(10'd3, 25, 25, 250, 1'b0);

    // Long phase length: one start sequence only
    settle_and_configure(10'd120);
    sender_idle_pct = 25;
    receiver_stall_pct = 25;
    run_sequence(CMD_START, 8'($urandom), 1'($urandom_range(1)), 2, 1'b0);

    run_random_phase(10'd1, 25, 25, 250, 1'b0);

    while (seq_model.busy()) send_item(CMD_TICK, 8'h00, 1'b0, 1'b1);
    s_axis_tvalid <= 1'b0;
    while (seq_model.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (seq_model.errors == 0 && seq_model.outstanding() == 0) begin
      $display("i2c_master_bit_sequencer_tb: PASS");
    end else begin
      $display("i2c_master_bit_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: i2c_master_bit_sequencer.f
+incdir+sv
sv/i2cbs_pkg.sv
sv/i2cbs_core.sv
sv/i2c_master_bit_sequencer.sv
verif/i2c_master_bit_sequencer_tb.sv
